[design/lrpu_pkg.sv]
// Package for the low-rank projection update block.
// Holds beat types, mode and register codes, command/status structs and Q16.16 helpers.
// No dependencies.
package lrpu_pkg;

   localparam int DEF_MAX_RANK    = 4;
   localparam int DEF_MAX_FRAMES  = 16;
   localparam int DEF_IMAGE_WORDS = 4096;

   localparam int ADR_W = 21;
   localparam int BX_W  = 11;
   localparam int RC_W  = 5;
   localparam int FC_W  = 7;

   localparam logic [2:0] MODE_LOAD_BASIS = 3'd0;
   localparam logic [2:0] MODE_LOAD_IMAGE = 3'd1;
   localparam logic [2:0] MODE_FORWARD    = 3'd2;
   localparam logic [2:0] MODE_BACK       = 3'd3;
   localparam logic [2:0] MODE_READ_IMAGE = 3'd4;
   localparam logic [2:0] MODE_FLUSH      = 3'd5;

   localparam logic [1:0] VAR_FRAMED  = 2'd1;
   localparam logic [1:0] VAR_LOWRANK = 2'd2;

   localparam logic [2:0] CSR_VARIANT  = 3'd0;
   localparam logic [2:0] CSR_RANKS    = 3'd1;
   localparam logic [2:0] CSR_FRAMES   = 3'd2;
   localparam logic [2:0] CSR_STRIDE   = 3'd3;
   localparam logic [2:0] CSR_UPD_BAS  = 3'd4;

   localparam logic [1:0] MUL_SW  = 2'd0;
   localparam logic [1:0] MUL_WS  = 2'd1;
   localparam logic [1:0] MUL_IB  = 2'd2;
   localparam logic [1:0] MUL_AYX = 2'd3;

   localparam logic [1:0] SUM_HOLD = 2'd0;
   localparam logic [1:0] SUM_IMG  = 2'd1;
   localparam logic [1:0] SUM_ADD  = 2'd2;

   localparam logic [1:0] RES_HOLD = 2'd0;
   localparam logic [1:0] RES_Q    = 2'd1;
   localparam logic [1:0] RES_IMG  = 2'd2;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] weight;
      logic signed [31:0] sample_value;
      logic [11:0]        voxel;
      logic [3:0]         frame;
      logic [1:0]         rank_index;
      logic signed [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [5:0]         entry_index;
      logic               error;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic       latch;
      logic       rd;
      logic [1:0] mul_sel;
      logic [1:0] sum_op;
      logic [1:0] res_op;
      logic       ay_ld;
      logic       wr_back;
      logic       wr_basis_load;
      logic       wr_image_load;
      logic       step_rank;
      logic       step_frame;
      logic       clr_start;
      logic       clr_step;
      logic       out_load;
      logic       out_flush;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       lowrank;
      logic       err;
      logic       rank_last;
      logic       frame_last;
      logic       clr_last;
      logic       out_free;
   } sts_type;

   function automatic logic signed [31:0] q_round(input logic signed [63:0] p);
      logic signed [64:0] s;
      logic signed [48:0] t;
      s = {p[63], p} + 65'sd32768;
      t = s[64:16];
      if (t > 49'sd2147483647) begin
         q_round = 32'sh7FFF_FFFF;
      end else if (t < -49'sd2147483648) begin
         q_round = 32'sh8000_0000;
      end else begin
         q_round = t[31:0];
      end
   endfunction

   function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         q_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         q_add = s[31:0];
      end
   endfunction

endpackage

[design/lrpu_ctrl.sv]
// Controller state machine for the low-rank projection update block.
// Sequences memory reads, multiplies, write-backs and result beats; uses lrpu_pkg.
module lrpu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lrpu_pkg::sts_type sts,
   output lrpu_pkg::cmd_type cmd
);
   import lrpu_pkg::*;

   localparam logic [4:0] S_RST  = 5'd0;
   localparam logic [4:0] S_CLR  = 5'd1;
   localparam logic [4:0] S_IDLE = 5'd2;
   localparam logic [4:0] S_DEC  = 5'd3;
   localparam logic [4:0] S_RDW  = 5'd4;
   localparam logic [4:0] S_FRD  = 5'd5;
   localparam logic [4:0] S_FMUL = 5'd6;
   localparam logic [4:0] S_FACC = 5'd7;
   localparam logic [4:0] S_WMUL = 5'd8;
   localparam logic [4:0] S_WRES = 5'd9;
   localparam logic [4:0] S_BAY  = 5'd10;
   localparam logic [4:0] S_BAYR = 5'd11;
   localparam logic [4:0] S_BRD  = 5'd12;
   localparam logic [4:0] S_BMUL = 5'd13;
   localparam logic [4:0] S_BWR  = 5'd14;
   localparam logic [4:0] S_EMIT = 5'd15;
   localparam logic [4:0] S_FLRD = 5'd16;
   localparam logic [4:0] S_FLEM = 5'd17;

   logic [4:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RST;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_RST: begin
            cmd.clr_start = 1'b1;
            state_in      = S_CLR;
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.mode == MODE_FLUSH) begin
               state_in = S_FLRD;
            end else if (sts.err) begin
               state_in = S_EMIT;
            end else if (sts.mode == MODE_LOAD_BASIS) begin
               cmd.wr_basis_load = 1'b1;
               state_in          = S_EMIT;
            end else if (sts.mode == MODE_LOAD_IMAGE) begin
               cmd.wr_image_load = 1'b1;
               state_in          = S_EMIT;
            end else if (sts.mode == MODE_READ_IMAGE) begin
               cmd.rd   = 1'b1;
               state_in = S_RDW;
            end else if (sts.mode == MODE_FORWARD) begin
               state_in = S_FRD;
            end else if (sts.mode == MODE_BACK) begin
               state_in = S_BAY;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_RDW: begin
            cmd.res_op = RES_IMG;
            state_in   = S_EMIT;
         end
         S_FRD: begin
            cmd.rd   = 1'b1;
            state_in = S_FMUL;
         end
         S_FMUL: begin
            cmd.mul_sel = MUL_IB;
            state_in    = S_FACC;
         end
         S_FACC: begin
            cmd.sum_op = sts.lowrank ? SUM_ADD : SUM_IMG;
            if (sts.lowrank && !sts.rank_last) begin
               cmd.step_rank = 1'b1;
               state_in      = S_FRD;
            end else begin
               state_in = S_WMUL;
            end
         end
         S_WMUL: begin
            cmd.mul_sel = MUL_WS;
            state_in    = S_WRES;
         end
         S_WRES: begin
            cmd.res_op = RES_Q;
            state_in   = S_EMIT;
         end
         S_BAY: begin
            cmd.mul_sel = MUL_SW;
            state_in    = S_BAYR;
         end
         S_BAYR: begin
            cmd.ay_ld = 1'b1;
            state_in  = S_BRD;
         end
         S_BRD: begin
            cmd.rd   = 1'b1;
            state_in = S_BMUL;
         end
         S_BMUL: begin
            cmd.mul_sel = MUL_AYX;
            state_in    = S_BWR;
         end
         S_BWR: begin
            cmd.wr_back = 1'b1;
            if (sts.lowrank && !sts.rank_last) begin
               cmd.step_rank = 1'b1;
               state_in      = S_BRD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FLRD: begin
            cmd.rd   = 1'b1;
            state_in = S_FLEM;
         end
         S_FLEM: begin
            if (sts.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_flush = 1'b1;
               if (!sts.rank_last) begin
                  cmd.step_rank = 1'b1;
                  state_in      = S_FLRD;
               end else if (!sts.frame_last) begin
                  cmd.step_frame = 1'b1;
                  state_in       = S_FLRD;
               end else begin
                  state_in = S_RST;
               end
            end
         end
         default: begin
            state_in = S_RST;
         end
      endcase
   end

endmodule

[design/lrpu_datapath.sv]
// Datapath for the low-rank projection update block: configuration registers,
// image, basis and accumulator memories, the Q16.16 multiplier and the result register.
// Uses lrpu_pkg.
module lrpu_datapath #(
   parameter int MAX_RANK    = lrpu_pkg::DEF_MAX_RANK,
   parameter int MAX_FRAMES  = lrpu_pkg::DEF_MAX_FRAMES,
   parameter int IMAGE_WORDS = lrpu_pkg::DEF_IMAGE_WORDS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [12:0]       csr_data,
   input  lrpu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lrpu_pkg::rsp_type rsp_data,
   input  lrpu_pkg::cmd_type cmd,
   output lrpu_pkg::sts_type sts
);
   import lrpu_pkg::*;

   localparam int IAW = $clog2(IMAGE_WORDS);
   localparam int BW  = MAX_RANK * MAX_FRAMES;
   localparam int BIW = (BW > 1) ? $clog2(BW) : 1;

   logic [1:0]  variant_ff;
   logic [2:0]  ranks_ff;
   logic [4:0]  frames_ff;
   logic [12:0] stride_ff;
   logic        upd_bas_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= VAR_LOWRANK;
         ranks_ff   <= 3'd1;
         frames_ff  <= 5'd1;
         stride_ff  <= 13'd4096;
         upd_bas_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_VARIANT: variant_ff <= csr_data[1:0];
            CSR_RANKS:   ranks_ff   <= csr_data[2:0];
            CSR_FRAMES:  frames_ff  <= csr_data[4:0];
            CSR_STRIDE:  stride_ff  <= csr_data;
            CSR_UPD_BAS: upd_bas_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   logic [RC_W-1:0] nr_c;
   logic [FC_W-1:0] nf_c;
   logic            lowrank_c;

   always_comb begin
      if (ranks_ff == 3'd0) begin
         nr_c = RC_W'(1);
      end else if (int'(ranks_ff) > MAX_RANK) begin
         nr_c = RC_W'(MAX_RANK);
      end else begin
         nr_c = RC_W'(ranks_ff);
      end
      if (frames_ff == 5'd0) begin
         nf_c = FC_W'(1);
      end else if (int'(frames_ff) > MAX_FRAMES) begin
         nf_c = FC_W'(MAX_FRAMES);
      end else begin
         nf_c = FC_W'(frames_ff);
      end
   end

   assign lowrank_c = (variant_ff == VAR_LOWRANK);

   req_type             item_ff;
   logic [ADR_W-1:0]    addr_ff, addr_in;
   logic [BX_W-1:0]     bidx_ff, bidx_in;
   logic [RC_W-1:0]     rcnt_ff, rcnt_in;
   logic [FC_W-1:0]     tcnt_ff, tcnt_in;
   logic                req_fwd_back;

   assign req_fwd_back = (req_data.mode == MODE_FORWARD) || (req_data.mode == MODE_BACK);

   always_comb begin
      addr_in = addr_ff;
      bidx_in = bidx_ff;
      rcnt_in = rcnt_ff;
      tcnt_in = tcnt_ff;
      if (cmd.latch) begin
         if ((variant_ff == VAR_FRAMED) && req_fwd_back) begin
            addr_in = ADR_W'(req_data.frame) * ADR_W'(stride_ff) + ADR_W'(req_data.voxel);
         end else begin
            addr_in = ADR_W'(req_data.voxel);
         end
         if (req_data.mode == MODE_FLUSH) begin
            bidx_in = '0;
         end else if (req_data.mode == MODE_LOAD_BASIS) begin
            bidx_in = BX_W'(req_data.rank_index) * BX_W'(nf_c) + BX_W'(req_data.frame);
         end else begin
            bidx_in = BX_W'(req_data.frame);
         end
         rcnt_in = '0;
         tcnt_in = '0;
      end else if (cmd.step_rank) begin
         addr_in = addr_ff + ADR_W'(stride_ff);
         bidx_in = bidx_ff + BX_W'(nf_c);
         rcnt_in = rcnt_ff + RC_W'(1);
      end else if (cmd.step_frame) begin
         rcnt_in = '0;
         tcnt_in = tcnt_ff + FC_W'(1);
         bidx_in = BX_W'(tcnt_ff) + BX_W'(1);
      end else if (cmd.clr_start) begin
         bidx_in = '0;
      end else if (cmd.clr_step) begin
         bidx_in = bidx_ff + BX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_ff <= req_data;
      end
      addr_ff <= addr_in;
      bidx_ff <= bidx_in;
      rcnt_ff <= rcnt_in;
      tcnt_ff <= tcnt_in;
   end

   logic [ADR_W-1:0] top_c;
   logic             image_oob;
   logic             err_c;
   logic             fwd_back;

   assign fwd_back = (item_ff.mode == MODE_FORWARD) || (item_ff.mode == MODE_BACK);
   assign top_c    = ADR_W'(nr_c - RC_W'(1)) * ADR_W'(stride_ff) + ADR_W'(item_ff.voxel);

   always_comb begin
      if (lowrank_c && fwd_back) begin
         image_oob = (top_c >= ADR_W'(IMAGE_WORDS));
      end else begin
         image_oob = (addr_ff >= ADR_W'(IMAGE_WORDS));
      end
      case (item_ff.mode)
         MODE_LOAD_BASIS: err_c = (int'(item_ff.rank_index) >= MAX_RANK)
                                  || (FC_W'(item_ff.frame) >= nf_c);
         MODE_LOAD_IMAGE: err_c = image_oob;
         MODE_READ_IMAGE: err_c = image_oob;
         MODE_FORWARD:    err_c = image_oob || (lowrank_c && (FC_W'(item_ff.frame) >= nf_c));
         MODE_BACK:       err_c = image_oob || (lowrank_c && (FC_W'(item_ff.frame) >= nf_c));
         default:         err_c = 1'b0;
      endcase
   end

   logic signed [31:0] image_mem [IMAGE_WORDS];
   logic signed [31:0] basis_mem [BW];
   logic signed [31:0] acc_mem   [BW];
   logic signed [31:0] img_rd_ff, bas_rd_ff, acc_rd_ff;
   logic signed [31:0] ay_ff, sum_ff, res_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] q_c, mul_a, mul_b, back_val, back_base, back_add;
   logic               acc_path;

   assign acc_path  = lowrank_c && upd_bas_ff;
   assign q_c       = q_round(prod_ff);
   assign back_base = acc_path ? acc_rd_ff : img_rd_ff;
   assign back_add  = lowrank_c ? q_c : ay_ff;
   assign back_val  = q_add(back_base, back_add);

   always_comb begin
      case (cmd.mul_sel)
         MUL_SW: begin
            mul_a = item_ff.sample_value;
            mul_b = item_ff.weight;
         end
         MUL_WS: begin
            mul_a = item_ff.weight;
            mul_b = sum_ff;
         end
         MUL_IB: begin
            mul_a = img_rd_ff;
            mul_b = bas_rd_ff;
         end
         default: begin
            mul_a = ay_ff;
            mul_b = upd_bas_ff ? img_rd_ff : bas_rd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.rd) begin
         img_rd_ff <= image_mem[addr_ff[IAW-1:0]];
         bas_rd_ff <= basis_mem[bidx_ff[BIW-1:0]];
         acc_rd_ff <= acc_mem[bidx_ff[BIW-1:0]];
      end
      if (cmd.wr_image_load) begin
         image_mem[addr_ff[IAW-1:0]] <= item_ff.load_data;
      end else if (cmd.wr_back && !acc_path) begin
         image_mem[addr_ff[IAW-1:0]] <= back_val;
      end
      if (cmd.wr_basis_load) begin
         basis_mem[bidx_ff[BIW-1:0]] <= item_ff.load_data;
      end
      if (cmd.clr_step) begin
         acc_mem[bidx_ff[BIW-1:0]] <= '0;
      end else if (cmd.wr_back && acc_path) begin
         acc_mem[bidx_ff[BIW-1:0]] <= back_val;
      end
      if (cmd.ay_ld) begin
         ay_ff <= q_c;
      end
      if (cmd.latch) begin
         sum_ff <= '0;
      end else if (cmd.sum_op == SUM_IMG) begin
         sum_ff <= img_rd_ff;
      end else if (cmd.sum_op == SUM_ADD) begin
         sum_ff <= q_add(sum_ff, q_c);
      end
      if (cmd.latch) begin
         res_ff <= '0;
      end else if (cmd.res_op == RES_Q) begin
         res_ff <= q_c;
      end else if (cmd.res_op == RES_IMG) begin
         res_ff <= img_rd_ff;
      end
   end

   logic    out_valid_ff;
   rsp_type out_ff;
   logic    rank_last_c, frame_last_c;

   assign rank_last_c  = (rcnt_ff == nr_c - RC_W'(1));
   assign frame_last_c = (tcnt_ff == nf_c - FC_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.out_flush) begin
            out_ff.result_value <= acc_rd_ff;
            out_ff.entry_index  <= bidx_ff[5:0];
            out_ff.error        <= 1'b0;
            out_ff.last         <= rank_last_c && frame_last_c;
         end else begin
            out_ff.result_value <= err_c ? 32'sd0 : res_ff;
            out_ff.entry_index  <= '0;
            out_ff.error        <= err_c;
            out_ff.last         <= 1'b1;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign sts.mode       = item_ff.mode;
   assign sts.lowrank    = lowrank_c;
   assign sts.err        = err_c;
   assign sts.rank_last  = rank_last_c;
   assign sts.frame_last = frame_last_c;
   assign sts.clr_last   = (bidx_ff == BX_W'(BW - 1));
   assign sts.out_free   = !out_valid_ff || !rsp_stall;

endmodule

[design/low_rank_projection_update.sv]
// Top level of the low-rank projection update block.
// Joins lrpu_ctrl and lrpu_datapath; uses lrpu_pkg.
//
// Usage: requests arrive as beats on req_valid/req_stall/req_data, results leave on
// rsp_valid/rsp_stall/rsp_data, and csr_write/csr_index/csr_data set the registers
// (variant, ranks, frames, stride, basis update). The user must write them only while
// the block is idle; the block itself does not enforce this. One request is worked at
// a time. Loads and errors end at decode, image reads add a memory read, forward sums
// per-rank products (plain forward takes the image word) and scales by the weight, and
// back reads and rewrites one memory word per rank, using the single multiplier and its
// rounding stage. A flush emits one beat per rank and frame in use, frames outer and
// ranks inner, then sweeps the accumulator to zero, one entry per cycle, over all
// MAX_RANK*MAX_FRAMES entries. After reset the same sweep runs with req_stall high.
// A result waits in the output register while rsp_stall is high; the next request is
// accepted meanwhile, and work halts only when the next result finds it still full.
module low_rank_projection_update #(
   parameter int MAX_RANK    = lrpu_pkg::DEF_MAX_RANK,
   parameter int MAX_FRAMES  = lrpu_pkg::DEF_MAX_FRAMES,
   parameter int IMAGE_WORDS = lrpu_pkg::DEF_IMAGE_WORDS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [12:0]       csr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  lrpu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lrpu_pkg::rsp_type rsp_data
);
   import lrpu_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lrpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lrpu_datapath #(
      .MAX_RANK    (MAX_RANK),
      .MAX_FRAMES  (MAX_FRAMES),
      .IMAGE_WORDS (IMAGE_WORDS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

[sim/tb_top.sv]
// Testbench for the low-rank projection update block: directed and random requests
// checked beat by beat against a behavioral predictor of images, basis and accumulator.
// Depends on lrpu_pkg and low_rank_projection_update.
module tb_top;
   import lrpu_pkg::*;

   localparam int N_RANK  = 4;
   localparam int N_FRAME = 16;
   localparam int N_WORDS = 4096;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [12:0] csr_data = '0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   low_rank_projection_update DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow state of the block.
   logic signed [31:0] img_mem [N_WORDS];
   logic signed [31:0] bas_tab [N_RANK*N_FRAME];
   logic signed [31:0] bas_acc [N_RANK*N_FRAME];
   bit   img_known [N_WORDS];
   logic [1:0]  cfg_variant;
   logic [2:0]  cfg_ranks;
   logic [4:0]  cfg_frames;
   logic [12:0] cfg_stride;
   logic        cfg_upd;

   rsp_type pending_rsp [$];
   int      fail_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   function automatic logic signed [31:0] fx_sat(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd32768;
      return fx_sat(p >>> 16);
   endfunction

   function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      return fx_sat(64'(a) + 64'(b));
   endfunction

   function automatic int used_ranks();
      if (cfg_ranks < 1) return 1;
      return (cfg_ranks > N_RANK) ? N_RANK : int'(cfg_ranks);
   endfunction

   function automatic int used_frames();
      if (cfg_frames < 1) return 1;
      return (cfg_frames > N_FRAME) ? N_FRAME : int'(cfg_frames);
   endfunction

   function automatic rsp_type mk_rsp(input logic signed [31:0] v, input int idx,
                                      input bit err, input bit lst);
      rsp_type r;
      r.result_value = v;
      r.entry_index  = idx[5:0];
      r.error        = err;
      r.last         = lst;
      return r;
   endfunction

   task automatic predict_request(input req_type q);
      int nr, nf, n, idx;
      int adr [N_RANK];
      bit lowrank, err;
      logic signed [31:0] res, sum, ay;
      nr = used_ranks();
      nf = used_frames();
      n = 1;
      lowrank = (cfg_variant == VAR_LOWRANK);
      err = 0;
      res = '0;
      if (q.mode == MODE_FLUSH) begin
         for (int t = 0; t < nf; t++)
            for (int r = 0; r < nr; r++) begin
               idx = r * nf + t;
               pending_rsp.push_back(mk_rsp(bas_acc[idx], idx, 0,
                                            r + 1 == nr && t + 1 == nf));
            end
         foreach (bas_acc[i]) bas_acc[i] = '0;
         return;
      end
      if (q.mode == MODE_LOAD_BASIS) begin
         if (q.frame >= nf) err = 1;
         else begin
            bas_tab[q.rank_index * nf + q.frame] = q.load_data;
         end
      end else if (q.mode == MODE_LOAD_IMAGE) begin
         img_mem[q.voxel] = q.load_data;
         img_known[q.voxel] = 1;
      end else if (q.mode == MODE_READ_IMAGE) begin
         res = img_mem[q.voxel];
      end else if (q.mode == MODE_FORWARD || q.mode == MODE_BACK) begin
         if (lowrank) begin
            n = nr;
            for (int r = 0; r < n; r++) adr[r] = r * int'(cfg_stride) + int'(q.voxel);
            if (q.frame >= nf) err = 1;
         end else if (cfg_variant == VAR_FRAMED) begin
            adr[0] = int'(q.frame) * int'(cfg_stride) + int'(q.voxel);
         end else begin
            adr[0] = int'(q.voxel);
         end
         for (int r = 0; r < n; r++) if (adr[r] >= N_WORDS) err = 1;
         if (!err) begin
            if (q.mode == MODE_FORWARD) begin
               if (lowrank) begin
                  sum = '0;
                  for (int r = 0; r < n; r++)
                     sum = fx_add(sum, fx_mul(img_mem[adr[r]], bas_tab[r * nf + q.frame]));
               end else begin
                  sum = img_mem[adr[0]];
               end
               res = fx_mul(q.weight, sum);
            end else begin
               ay = fx_mul(q.sample_value, q.weight);
               if (!lowrank) begin
                  img_mem[adr[0]] = fx_add(img_mem[adr[0]], ay);
               end else if (!cfg_upd) begin
                  for (int r = 0; r < n; r++)
                     img_mem[adr[r]] = fx_add(img_mem[adr[r]],
                                              fx_mul(ay, bas_tab[r * nf + q.frame]));
               end else begin
                  for (int r = 0; r < n; r++) begin
                     idx = r * nf + q.frame;
                     bas_acc[idx] = fx_add(bas_acc[idx], fx_mul(ay, img_mem[adr[r]]));
                  end
               end
            end
         end
      end
      pending_rsp.push_back(mk_rsp(err ? 32'sd0 : res, 0, err, 1));
   endtask

   // Result checker.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected beat: actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.result_value !== exp_rsp.result_value) begin
               $display("%0t result_value: expected %h actual %h", $time,
                        exp_rsp.result_value, rsp_data.result_value);
               fail_count++;
            end
            if (rsp_data.entry_index !== exp_rsp.entry_index) begin
               $display("%0t entry_index: expected %0d actual %0d", $time,
                        exp_rsp.entry_index, rsp_data.entry_index);
               fail_count++;
            end
            if (rsp_data.error !== exp_rsp.error) begin
               $display("%0t error: expected %b actual %b", $time,
                        exp_rsp.error, rsp_data.error);
               fail_count++;
            end
            if (rsp_data.last !== exp_rsp.last) begin
               $display("%0t last: expected %b actual %b", $time,
                        exp_rsp.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   // Receiver stall pattern.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_request(input req_type q);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(q);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0 || req_stall) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         CSR_VARIANT: cfg_variant = val[1:0];
         CSR_RANKS:   cfg_ranks = val[2:0];
         CSR_FRAMES:  cfg_frames = val[4:0];
         CSR_STRIDE:  cfg_stride = val;
         CSR_UPD_BAS: cfg_upd = val[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [1:0] v, input logic [2:0] r, input logic [4:0] f,
                            input logic [12:0] s, input bit u);
      wait_drained();
      write_reg(CSR_VARIANT, 13'(v));
      write_reg(CSR_RANKS, 13'(r));
      write_reg(CSR_FRAMES, 13'(f));
      write_reg(CSR_STRIDE, s);
      write_reg(CSR_UPD_BAS, 13'(u));
      csr_write <= 1'b0;
   endtask

   function automatic req_type blank_req(input logic [2:0] m);
      req_type q;
      q = '0;
      q.mode = m;
      return q;
   endfunction

   task automatic load_image(input int adr, input logic signed [31:0] v);
      req_type q;
      q = blank_req(MODE_LOAD_IMAGE);
      q.voxel = adr[11:0];
      q.load_data = v;
      send_request(q);
   endtask

   task automatic load_basis(input int r, input int f, input logic signed [31:0] v);
      req_type q;
      q = blank_req(MODE_LOAD_BASIS);
      q.rank_index = r[1:0];
      q.frame = f[3:0];
      q.load_data = v;
      send_request(q);
   endtask

   // Fill a window of image words and the basis table so reads stay defined.
   task automatic test_preload();
      for (int a = 0; a < 16; a++) load_image(a, $urandom);
      for (int a = 0; a < 4; a++) load_image(N_WORDS - 1 - a, 32'sh7FFF_FFFF);
      for (int r = 0; r < N_RANK; r++)
         for (int f = 0; f < used_frames(); f++)
            load_basis(r, f, (r == 0 && f == 0) ? 32'sh8000_0000 : $urandom);
   endtask

   task automatic test_directed();
      req_type q;
      q = blank_req(MODE_READ_IMAGE);
      q.voxel = 12'hFFF;
      send_request(q);
      q = blank_req(MODE_FORWARD);
      q.weight = 32'sh8000_0000;
      q.voxel = 12'hFFF;
      send_request(q);
      q.weight = 32'sh7FFF_FFFF;
      q.voxel = 0;
      send_request(q);
      q = blank_req(MODE_BACK);
      q.weight = 32'sh7FFF_FFFF;
      q.sample_value = 32'sh7FFF_FFFF;
      q.voxel = 12'hFFF;
      send_request(q);
      q.frame = 4'hF;
      send_request(q);
      load_basis(3, 15, 32'sh0001_0000);
      send_request(blank_req(3'd6));
      send_request(blank_req(3'd7));
      send_request(blank_req(MODE_FLUSH));
   endtask

   // True when every word the request may read has been written or lies out of range.
   function automatic bit img_ok(input req_type q);
      int a;
      if (q.mode == MODE_READ_IMAGE) return img_known[q.voxel];
      if (cfg_variant == VAR_LOWRANK) begin
         if (q.frame >= used_frames()) return 1;
         for (int r = 0; r < used_ranks(); r++) begin
            a = r * int'(cfg_stride) + int'(q.voxel);
            if (a >= N_WORDS) return 1;
         end
         for (int r = 0; r < used_ranks(); r++)
            if (!img_known[r * int'(cfg_stride) + int'(q.voxel)]) return 0;
         return 1;
      end
      a = (cfg_variant == VAR_FRAMED) ? int'(q.frame) * int'(cfg_stride) + int'(q.voxel)
                                      : int'(q.voxel);
      return a >= N_WORDS || img_known[a];
   endfunction

   // Low-rank phase: valid and out-of-range frames and voxels, with some flushes and image reads.
   task automatic test_random_lowrank(input int count);
      req_type q;
      for (int i = 0; i < count; i++) begin
         q = blank_req(3'($urandom_range(99) < 45 ? MODE_FORWARD : MODE_BACK));
         q.weight = $urandom;
         q.sample_value = $urandom;
         q.voxel = 12'($urandom_range(15));
         q.frame = 4'($urandom_range(used_frames() - 1 + ($urandom_range(9) == 0)));
         if ($urandom_range(9) == 0) q.voxel = 12'($urandom_range(4095));
         else if ($urandom_range(9) == 0) q.voxel = 12'(N_WORDS - 1 - $urandom_range(3));
         if (!img_ok(q)) q.voxel = 12'(N_WORDS - 1);
         if ($urandom_range(11) == 0) q = blank_req(MODE_FLUSH);
         else if ($urandom_range(11) == 0) begin
            q.mode = MODE_READ_IMAGE;
            q.voxel = 12'($urandom_range(15));
         end
         send_request(q);
      end
   endtask

   task automatic test_random_voxel(input int count);
      req_type q;
      for (int i = 0; i < count; i++) begin
         q = blank_req(3'($urandom_range(MODE_FORWARD, MODE_READ_IMAGE)));
         q.weight = $urandom;
         q.sample_value = $urandom;
         q.voxel = 12'($urandom_range(4095));
         q.frame = 4'($urandom_range(15));
         if ($urandom_range(2) != 0) q.voxel = 12'($urandom_range(15));
         if (!img_ok(q)) begin
            q.mode = MODE_LOAD_IMAGE;
            q.load_data = $urandom;
         end
         send_request(q);
      end
   endtask

   initial begin
      cfg_variant = VAR_LOWRANK;
      cfg_ranks = 1;
      cfg_frames = 1;
      cfg_stride = 13'd4096;
      cfg_upd = 0;
      foreach (bas_acc[i]) bas_acc[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_stall) @(posedge clock);

      configure(VAR_LOWRANK, 3'd4, 5'd4, 13'd4, 0);
      test_preload();
      test_directed();
      send_idle_pct = 37;
      recv_idle_pct = 68;
      test_random_lowrank(12);
      configure(VAR_LOWRANK, 3'd7, 5'd4, 13'd1, 1);
      test_random_lowrank(12);
      send_request(blank_req(MODE_FLUSH));
      // Sender holds off until every expected beat has come back.
      wait_drained();
      send_idle_pct = 68;
      recv_idle_pct = 37;
      configure(VAR_LOWRANK, 3'd0, 5'd0, 13'd4096, 1);
      test_random_lowrank(6);
      send_request(blank_req(MODE_FLUSH));
      configure(VAR_FRAMED, 3'd2, 5'd3, 13'd2, 0);
      test_random_voxel(10);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(2'd3, 3'd1, 5'd1, 13'd8191, 0);
      test_random_voxel(10);
      configure(2'd0, 3'd1, 5'd1, 13'd1, 0);
      test_random_voxel(6);
      configure(VAR_LOWRANK, 3'd3, 5'd2, 13'd5, 1);
      test_random_lowrank(8);
      send_request(blank_req(MODE_FLUSH));
      wait_drained();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end

endmodule
